FILE: design/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and reset values of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int ROM_BITS_DEF     = 64;
    localparam int SETTLE_TICKS_DEF = 2;
    localparam int TICK_W           = 11;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 11;

    localparam logic [10:0] RESET_LOW_DEF   = 11'd640;
    localparam logic [7:0]  PRES_WIN_DEF    = 8'd80;
    localparam logic [7:0]  WR_ONE_LOW_DEF  = 8'd5;
    localparam logic [7:0]  WR_ZERO_LOW_DEF = 8'd90;
    localparam logic [7:0]  WR_SLOT_DEF     = 8'd95;
    localparam logic [7:0]  RD_LOW_DEF      = 8'd2;
    localparam logic [7:0]  RD_SAMPLE_DEF   = 8'd8;
    localparam logic [7:0]  RD_TAIL_DEF     = 8'd80;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_RESET   = 3'd1,
        CMD_WR_BYTE = 3'd2,
        CMD_RD_BYTE = 3'd3,
        CMD_WR_BIT  = 3'd4,
        CMD_RD_BIT  = 3'd5,
        CMD_SEARCH  = 3'd6,
        CMD_INIT    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_RESET_LOW   = 3'd0,
        CFG_PRES_WIN    = 3'd1,
        CFG_WR_ONE_LOW  = 3'd2,
        CFG_WR_ZERO_LOW = 3'd3,
        CFG_WR_SLOT     = 3'd4,
        CFG_RD_LOW      = 3'd5,
        CFG_RD_SAMPLE   = 3'd6,
        CFG_RD_TAIL     = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_SETTLE,
        PH_RST_WAIT,
        PH_RST_HOLD,
        PH_WR,
        PH_RD
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       bus;
    } item_t;

    function automatic logic [7:0] at_least1(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

FILE: design/owbm_front.sv
// ----------------------------------------------------------------------------
// owbm_front
// Accepts ticks, decodes the command code and queues them for the engine.
// ----------------------------------------------------------------------------
module owbm_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic [7:0]         s_data_byte,
    input  logic               s_bus_level,
    output logic               q_valid,
    input  logic               q_pop,
    output owbm_pkg::item_t    q_item
);

    owbm_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    owbm_pkg::item_t in_item;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_pop;

    always_comb begin
        in_item.cmd  = owbm_pkg::cmd_t'(s_func);
        in_item.data = s_data_byte;
        in_item.bus  = s_bus_level;
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: design/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Runs bus reset, read/write slots and search-ROM steps, one tick per cycle unless m_ stalls.
// ----------------------------------------------------------------------------
module owbm_engine #(
    parameter int ROM_BITS             = owbm_pkg::ROM_BITS_DEF,
    parameter int RELEASE_SETTLE_TICKS = owbm_pkg::SETTLE_TICKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  owbm_pkg::item_t                     q_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_drive_low,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic                                m_presence,
    output logic [7:0]                          m_read_data,
    output logic                                m_search_direction,
    output logic                                m_search_error,
    output logic                                m_search_pass_done,
    output logic                                m_search_exhausted,
    output logic [ROM_BITS-1:0]                 m_rom_code
);

    localparam int POS_W    = $clog2(ROM_BITS + 2);
    localparam int IDX_W    = $clog2(ROM_BITS);
    localparam int SETTLE_N = (RELEASE_SETTLE_TICKS < 1) ? 1 : RELEASE_SETTLE_TICKS;
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(ROM_BITS);
    localparam logic [POS_W-1:0] POS_INIT = POS_W'(ROM_BITS + 1);

    logic [10:0] reset_low_reg;
    logic [7:0]  pres_win_reg, wr_one_reg, wr_zero_reg, wr_slot_reg;
    logic [7:0]  rd_low_reg, rd_sample_reg, rd_tail_reg;

    owbm_pkg::phase_t phase_reg, phase_next;
    owbm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [owbm_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]          bit_reg, bit_next;
    logic [7:0]          shift_reg, shift_next;
    logic [1:0]          pair_reg, pair_next;
    logic [ROM_BITS-1:0] rom_reg, rom_next;
    logic [POS_W-1:0]    last_reg, last_next;
    logic [POS_W-1:0]    new_reg, new_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                pres_reg, pres_next;
    logic [7:0]          rdata_reg, rdata_next;
    logic                dir_reg, dir_next;
    logic                err_reg, err_next;
    logic                pass_reg, pass_next;
    logic                drive_next, done_next;

    logic                m_valid_reg;
    logic                drive_out_reg, busy_out_reg, done_out_reg;
    logic                fire;

    assign cfg_ready = 1'b1;
    assign fire      = q_valid && (!m_valid_reg || m_ready);
    assign q_pop     = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg <= owbm_pkg::RESET_LOW_DEF;
            pres_win_reg  <= owbm_pkg::PRES_WIN_DEF;
            wr_one_reg    <= owbm_pkg::WR_ONE_LOW_DEF;
            wr_zero_reg   <= owbm_pkg::WR_ZERO_LOW_DEF;
            wr_slot_reg   <= owbm_pkg::WR_SLOT_DEF;
            rd_low_reg    <= owbm_pkg::RD_LOW_DEF;
            rd_sample_reg <= owbm_pkg::RD_SAMPLE_DEF;
            rd_tail_reg   <= owbm_pkg::RD_TAIL_DEF;
        end else if (cfg_valid && cfg_ready) begin
            unique case (owbm_pkg::cfg_index_t'(cfg_index))
                owbm_pkg::CFG_RESET_LOW:   reset_low_reg <= cfg_data;
                owbm_pkg::CFG_PRES_WIN:    pres_win_reg  <= cfg_data[7:0];
                owbm_pkg::CFG_WR_ONE_LOW:  wr_one_reg    <= cfg_data[7:0];
                owbm_pkg::CFG_WR_ZERO_LOW: wr_zero_reg   <= cfg_data[7:0];
                owbm_pkg::CFG_WR_SLOT:     wr_slot_reg   <= cfg_data[7:0];
                owbm_pkg::CFG_RD_LOW:      rd_low_reg    <= cfg_data[7:0];
                owbm_pkg::CFG_RD_SAMPLE:   rd_sample_reg <= cfg_data[7:0];
                owbm_pkg::CFG_RD_TAIL:     rd_tail_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin : step_comb
        logic [11:0]      t;
        logic [10:0]      rst_low;
        logic [8:0]       wlow, wtot;
        logic [9:0]       rlow, rsamp, rtot;
        logic             end_slot, s_bit, dir;
        logic [POS_W-1:0] pm1;

        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pair_next  = pair_reg;
        rom_next   = rom_reg;
        last_next  = last_reg;
        new_next   = new_reg;
        pos_next   = pos_reg;
        pres_next  = pres_reg;
        rdata_next = rdata_reg;
        dir_next   = dir_reg;
        err_next   = err_reg;
        pass_next  = pass_reg;
        drive_next = 1'b0;
        done_next  = 1'b0;
        end_slot   = 1'b0;
        s_bit      = 1'b0;
        dir        = 1'b0;
        t          = 12'd0;
        rst_low    = (reset_low_reg == 11'd0) ? 11'd1 : reset_low_reg;
        wlow       = 9'd0;
        wtot       = 9'd0;
        rlow       = 10'(owbm_pkg::at_least1(rd_low_reg));
        rsamp      = rlow + 10'(owbm_pkg::at_least1(rd_sample_reg));
        rtot       = rsamp + 10'(owbm_pkg::at_least1(rd_tail_reg));
        pm1        = pos_reg - POS_ONE;

        if (phase_reg == owbm_pkg::PH_IDLE && q_item.cmd != owbm_pkg::CMD_NONE) begin
            cmd_next  = q_item.cmd;
            bit_next  = 4'd0;
            tick_next = '0;
            unique case (q_item.cmd)
                owbm_pkg::CMD_RESET: phase_next = owbm_pkg::PH_RST_LOW;
                owbm_pkg::CMD_WR_BYTE: begin
                    shift_next = q_item.data;
                    phase_next = owbm_pkg::PH_WR;
                end
                owbm_pkg::CMD_RD_BYTE: begin
                    shift_next = 8'd0;
                    phase_next = owbm_pkg::PH_RD;
                end
                owbm_pkg::CMD_WR_BIT: begin
                    shift_next = {7'd0, q_item.data[0]};
                    phase_next = owbm_pkg::PH_WR;
                end
                owbm_pkg::CMD_RD_BIT: phase_next = owbm_pkg::PH_RD;
                owbm_pkg::CMD_SEARCH: begin
                    err_next  = 1'b0;
                    pass_next = 1'b0;
                    if (last_reg == '0) begin
                        done_next = 1'b1;
                    end else begin
                        pair_next  = 2'd0;
                        phase_next = owbm_pkg::PH_RD;
                    end
                end
                default: begin
                    rom_next  = '0;
                    last_next = POS_INIT;
                    new_next  = '0;
                    pos_next  = POS_ONE;
                    err_next  = 1'b0;
                    pass_next = 1'b0;
                    dir_next  = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end

        t = {1'b0, tick_next} + 12'd1;
        unique case (phase_next)
            owbm_pkg::PH_RST_LOW: begin
                drive_next = 1'b1;
                if (t >= 12'(rst_low)) begin
                    phase_next = owbm_pkg::PH_RST_SETTLE;
                    tick_next  = '0;
                end else begin
                    tick_next = t[10:0];
                end
            end
            owbm_pkg::PH_RST_SETTLE: begin
                if (t >= 12'(SETTLE_N)) begin
                    phase_next = owbm_pkg::PH_RST_WAIT;
                    tick_next  = '0;
                end else begin
                    tick_next = t[10:0];
                end
            end
            owbm_pkg::PH_RST_WAIT: begin
                if (!q_item.bus) begin
                    phase_next = owbm_pkg::PH_RST_HOLD;
                end else if (t >= 12'(pres_win_reg)
                             || (pres_win_reg == 8'd0)) begin
                    pres_next  = 1'b0;
                    phase_next = owbm_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end else begin
                    tick_next = t[10:0];
                end
            end
            owbm_pkg::PH_RST_HOLD: begin
                if (q_item.bus) begin
                    pres_next  = 1'b1;
                    phase_next = owbm_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            owbm_pkg::PH_WR: begin
                wlow = 9'(owbm_pkg::at_least1(shift_next[0] ? wr_one_reg : wr_zero_reg));
                wtot = ({1'b0, wr_slot_reg} > wlow) ? {1'b0, wr_slot_reg} : wlow + 9'd1;
                drive_next = ({1'b0, tick_next} < 12'(wlow));
                tick_next  = t[10:0];
                if (t >= 12'(wtot)) begin
                    end_slot = 1'b1;
                end
            end
            owbm_pkg::PH_RD: begin
                drive_next = ({1'b0, tick_next} < 12'(rlow));
                if (t == 12'(rsamp)) begin
                    pair_next = {q_item.bus, pair_next[0]};
                end
                tick_next = t[10:0];
                if (t >= 12'(rtot)) begin
                    end_slot = 1'b1;
                    s_bit    = pair_next[1];
                end
            end
            default: ;
        endcase

        if (end_slot) begin
            unique case (cmd_next)
                owbm_pkg::CMD_WR_BYTE: begin
                    bit_next = bit_next + 4'd1;
                    if (bit_next >= 4'd8) begin
                        phase_next = owbm_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        shift_next = {1'b0, shift_next[7:1]};
                        phase_next = owbm_pkg::PH_WR;
                        tick_next  = '0;
                    end
                end
                owbm_pkg::CMD_RD_BYTE: begin
                    shift_next = {s_bit, shift_next[7:1]};
                    bit_next   = bit_next + 4'd1;
                    if (bit_next >= 4'd8) begin
                        rdata_next = shift_next;
                        phase_next = owbm_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        phase_next = owbm_pkg::PH_RD;
                        tick_next  = '0;
                    end
                end
                owbm_pkg::CMD_RD_BIT: begin
                    rdata_next = {7'd0, s_bit};
                    phase_next = owbm_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                owbm_pkg::CMD_SEARCH: begin
                    if (bit_next == 4'd0) begin
                        pair_next  = {1'b0, s_bit};
                        bit_next   = 4'd1;
                        phase_next = owbm_pkg::PH_RD;
                        tick_next  = '0;
                    end else if (bit_next == 4'd1) begin
                        if (pair_next[0] && pair_next[1]) begin
                            err_next   = 1'b1;
                            pos_next   = POS_ONE;
                            new_next   = '0;
                            phase_next = owbm_pkg::PH_IDLE;
                            done_next  = 1'b1;
                        end else begin
                            if (pair_next[0]) begin
                                dir = 1'b1;
                            end else if (pair_next[1]) begin
                                dir = 1'b0;
                            end else if (pos_reg < last_reg) begin
                                dir = rom_reg[pm1[IDX_W-1:0]];
                                if (!dir) begin
                                    new_next = pos_reg;
                                end
                            end else if (pos_reg == last_reg) begin
                                dir = 1'b1;
                            end else begin
                                dir      = 1'b0;
                                new_next = pos_reg;
                            end
                            dir_next   = dir;
                            bit_next   = 4'd2;
                            shift_next = {7'd0, dir};
                            phase_next = owbm_pkg::PH_WR;
                            tick_next  = '0;
                        end
                    end else begin
                        rom_next[pm1[IDX_W-1:0]] = dir_reg;
                        if (pos_reg >= POS_LAST) begin
                            last_next = new_next;
                            new_next  = '0;
                            pos_next  = POS_ONE;
                            pass_next = 1'b1;
                        end else begin
                            pos_next = pos_reg + POS_ONE;
                        end
                        phase_next = owbm_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                    phase_next = owbm_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= owbm_pkg::PH_IDLE;
            cmd_reg     <= owbm_pkg::CMD_NONE;
            tick_reg    <= '0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            pair_reg    <= 2'd0;
            rom_reg     <= '0;
            last_reg    <= POS_INIT;
            new_reg     <= '0;
            pos_reg     <= POS_ONE;
            pres_reg    <= 1'b0;
            rdata_reg   <= 8'd0;
            dir_reg     <= 1'b0;
            err_reg     <= 1'b0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                pair_reg  <= pair_next;
                rom_reg   <= rom_next;
                last_reg  <= last_next;
                new_reg   <= new_next;
                pos_reg   <= pos_next;
                pres_reg  <= pres_next;
                rdata_reg <= rdata_next;
                dir_reg   <= dir_next;
                err_reg   <= err_next;
                pass_reg  <= pass_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            drive_out_reg <= drive_next;
            busy_out_reg  <= (phase_next != owbm_pkg::PH_IDLE);
            done_out_reg  <= done_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_drive_low        = drive_out_reg;
    assign m_busy_res         = busy_out_reg;
    assign m_done_res         = done_out_reg;
    assign m_presence         = pres_reg;
    assign m_read_data        = rdata_reg;
    assign m_search_direction = dir_reg;
    assign m_search_error     = err_reg;
    assign m_search_pass_done = pass_reg;
    assign m_search_exhausted = (last_reg == '0);
    assign m_rom_code         = rom_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_out_reg |-> !busy_out_reg)
        else $error("done reported while still busy");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != '0 && pos_reg <= POS_LAST)
        else $error("search position out of range");

    a_fork_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_reg <= POS_INIT && new_reg < POS_INIT)
        else $error("fork index out of range");

    a_pass_err: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pass_reg && err_reg))
        else $error("pass done and search error both set");

endmodule

FILE: design/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master with bus reset, bit/byte transfers and search-ROM steps.
//
// Each transfer on the s_ channel is one microsecond tick: the sampled line
// level plus an optional command, taken only while no command runs. Every
// tick yields exactly one transfer on the m_ channel carrying the line drive
// for that tick and the command status.
// Ticks go into a two-entry queue; the engine takes one tick per cycle when
// the m_ output register is empty or being drained. An s_ transfer passes
// through a queue slot and then the m_ output register before m_valid.
// The cfg_ channel writes timing registers, always ready; write only while no
// command runs.
// A stalled m_ready holds the result and fills the queue, then drops s_ready.
// Reset clears the queue, the command state and the search state and loads
// the default timing.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int ROM_BITS             = owbm_pkg::ROM_BITS_DEF,
    parameter int RELEASE_SETTLE_TICKS = owbm_pkg::SETTLE_TICKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_func,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_bus_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_drive_low,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic                                m_presence,
    output logic [7:0]                          m_read_data,
    output logic                                m_search_direction,
    output logic                                m_search_error,
    output logic                                m_search_pass_done,
    output logic                                m_search_exhausted,
    output logic [ROM_BITS-1:0]                 m_rom_code
);

    logic            q_valid;
    logic            q_pop;
    owbm_pkg::item_t q_item;

    owbm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_byte (s_data_byte),
        .s_bus_level (s_bus_level),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    owbm_engine #(
        .ROM_BITS             (ROM_BITS),
        .RELEASE_SETTLE_TICKS (RELEASE_SETTLE_TICKS)
    ) u_engine (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .q_valid            (q_valid),
        .q_pop              (q_pop),
        .q_item             (q_item),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_drive_low        (m_drive_low),
        .m_busy_res         (m_busy_res),
        .m_done_res         (m_done_res),
        .m_presence         (m_presence),
        .m_read_data        (m_read_data),
        .m_search_direction (m_search_direction),
        .m_search_error     (m_search_error),
        .m_search_pass_done (m_search_pass_done),
        .m_search_exhausted (m_search_exhausted),
        .m_rom_code         (m_rom_code)
    );

endmodule

FILE: verif/one_wire_bus_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Tick-level check of the 1-Wire bus master. Every tick transfer on the s_
// channel is run through a cycle-true line engine in the bench, and each m_
// transfer is compared field by field with the oldest predicted tick result.
// Covers bus reset with and without presence, bit and byte writes and reads,
// search passes with forks, aborted passes and exhaustion, ignored commands
// while busy, and timing registers at zero, small and default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 60;

    typedef struct packed {
        logic        drive;
        logic        busy;
        logic        done;
        logic        pres;
        logic [7:0]  rdata;
        logic        dir;
        logic        err;
        logic        pass;
        logic        exh;
        logic [63:0] rom;
    } tick_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [7:0]  s_data_byte = '0;
    logic        s_bus_level = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_drive_low, m_busy_res, m_done_res, m_presence;
    logic [7:0]  m_read_data;
    logic        m_search_direction, m_search_error, m_search_pass_done;
    logic        m_search_exhausted;
    logic [63:0] m_rom_code;

    one_wire_bus_master DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // line engine state
    logic [10:0]       t_rst_low;
    logic [7:0]        t_pres_win, t_one_low, t_zero_low, t_slot, t_rd_low, t_rd_samp, t_rd_tail;
    owbm_pkg::phase_t  ph;
    owbm_pkg::cmd_t    run_cmd;
    int unsigned       tcnt, bcnt, last_fk, new_fk, spos;
    logic [7:0]        shreg, rdata_r;
    logic [1:0]        pairs;
    logic [63:0]       rom_r;
    logic              pres_r, dir_r, err_r, pass_r, done_f;

    owbm_pkg::item_t   pend_q[$];
    tick_result_t      tick_q[$];
    int           mismatches = 0;
    int           n_ticks = 0, n_results = 0, n_done = 0, n_pres = 0, n_pass = 0;
    int           n_err = 0, n_exh = 0;
    int           stall_cnt = 0;
    int           s_gap = 0, m_wait = 0;
    logic         s_took = 1'b0;
    logic         idle_on = 1'b1;
    logic         hold_req = 1'b0;

    function automatic int unsigned min1(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic engine_reset();
        t_rst_low = owbm_pkg::RESET_LOW_DEF;    t_pres_win = owbm_pkg::PRES_WIN_DEF;
        t_one_low = owbm_pkg::WR_ONE_LOW_DEF;   t_zero_low = owbm_pkg::WR_ZERO_LOW_DEF;
        t_slot    = owbm_pkg::WR_SLOT_DEF;      t_rd_low   = owbm_pkg::RD_LOW_DEF;
        t_rd_samp = owbm_pkg::RD_SAMPLE_DEF;    t_rd_tail  = owbm_pkg::RD_TAIL_DEF;
        ph = owbm_pkg::PH_IDLE; run_cmd = owbm_pkg::CMD_NONE;
        tcnt = 0; bcnt = 0; shreg = 0; pairs = 0; rom_r = 0;
        last_fk = 65; new_fk = 0; spos = 1;
        pres_r = 0; rdata_r = 0; dir_r = 0; err_r = 0; pass_r = 0; done_f = 0;
    endtask

    task automatic engine_cfg(owbm_pkg::cfg_index_t idx, logic [10:0] d);
        case (idx)
            owbm_pkg::CFG_RESET_LOW:   t_rst_low  = d;
            owbm_pkg::CFG_PRES_WIN:    t_pres_win = d[7:0];
            owbm_pkg::CFG_WR_ONE_LOW:  t_one_low  = d[7:0];
            owbm_pkg::CFG_WR_ZERO_LOW: t_zero_low = d[7:0];
            owbm_pkg::CFG_WR_SLOT:     t_slot     = d[7:0];
            owbm_pkg::CFG_RD_LOW:      t_rd_low   = d[7:0];
            owbm_pkg::CFG_RD_SAMPLE:   t_rd_samp  = d[7:0];
            owbm_pkg::CFG_RD_TAIL:     t_rd_tail  = d[7:0];
            default: ;
        endcase
    endtask

    task automatic finish_cmd();
        ph = owbm_pkg::PH_IDLE;
        done_f = 1'b1;
    endtask

    task automatic open_write(logic [7:0] b);
        shreg = b; ph = owbm_pkg::PH_WR; tcnt = 0;
    endtask

    task automatic open_read();
        ph = owbm_pkg::PH_RD; tcnt = 0;
    endtask

    task automatic slot_end(logic s);
        logic [63:0] m;
        logic d;
        case (run_cmd)
            owbm_pkg::CMD_WR_BYTE: begin
                bcnt++;
                if (bcnt >= 8) finish_cmd();
                else open_write(shreg >> 1);
            end
            owbm_pkg::CMD_RD_BYTE: begin
                shreg = {s, shreg[7:1]};
                bcnt++;
                if (bcnt >= 8) begin
                    rdata_r = shreg;
                    finish_cmd();
                end else open_read();
            end
            owbm_pkg::CMD_RD_BIT: begin
                rdata_r = {7'd0, s};
                finish_cmd();
            end
            owbm_pkg::CMD_SEARCH: begin
                if (bcnt == 0) begin
                    pairs = {1'b0, s};
                    bcnt = 1;
                    open_read();
                end else if (bcnt == 1) begin
                    pairs = pairs | {s, 1'b0};
                    if (pairs == 2'b11) begin
                        err_r = 1; spos = 1; new_fk = 0;
                        finish_cmd();
                    end else begin
                        if (pairs[0]) d = 1;
                        else if (pairs[1]) d = 0;
                        else if (spos < last_fk) begin
                            d = rom_r[(spos - 1) & 63];
                            if (!d) new_fk = spos;
                        end else if (spos == last_fk) d = 1;
                        else begin
                            d = 0;
                            new_fk = spos;
                        end
                        dir_r = d;
                        bcnt = 2;
                        open_write({7'd0, d});
                    end
                end else begin
                    m = 64'd1 << ((spos - 1) & 63);
                    rom_r = dir_r ? (rom_r | m) : (rom_r & ~m);
                    if (spos >= 64) begin
                        last_fk = new_fk; new_fk = 0; spos = 1; pass_r = 1;
                    end else spos++;
                    finish_cmd();
                end
            end
            default: finish_cmd();
        endcase
    endtask

    task automatic engine_tick(owbm_pkg::cmd_t f, logic [7:0] d, logic b,
                               output tick_result_t r);
        int unsigned low, samp, total;
        logic drv;
        drv = 0;
        done_f = 0;
        if (ph == owbm_pkg::PH_IDLE && f != owbm_pkg::CMD_NONE) begin
            run_cmd = f; bcnt = 0; tcnt = 0;
            case (f)
                owbm_pkg::CMD_RESET:   ph = owbm_pkg::PH_RST_LOW;
                owbm_pkg::CMD_WR_BYTE: open_write(d);
                owbm_pkg::CMD_RD_BYTE: begin
                    shreg = 0;
                    open_read();
                end
                owbm_pkg::CMD_WR_BIT:  open_write({7'd0, d[0]});
                owbm_pkg::CMD_RD_BIT:  open_read();
                owbm_pkg::CMD_SEARCH: begin
                    err_r = 0; pass_r = 0;
                    if (last_fk == 0) finish_cmd();
                    else begin
                        pairs = 0;
                        open_read();
                    end
                end
                default: begin
                    rom_r = 0; last_fk = 65; new_fk = 0; spos = 1;
                    err_r = 0; pass_r = 0; dir_r = 0;
                    finish_cmd();
                end
            endcase
        end
        case (ph)
            owbm_pkg::PH_RST_LOW: begin
                drv = 1;
                if (++tcnt >= min1(t_rst_low)) begin
                    ph = owbm_pkg::PH_RST_SETTLE; tcnt = 0;
                end
            end
            owbm_pkg::PH_RST_SETTLE: begin
                if (++tcnt >= min1(owbm_pkg::SETTLE_TICKS_DEF)) begin
                    ph = owbm_pkg::PH_RST_WAIT; tcnt = 0;
                end
            end
            owbm_pkg::PH_RST_WAIT: begin
                if (!b) ph = owbm_pkg::PH_RST_HOLD;
                else if (++tcnt >= min1(t_pres_win)) begin
                    pres_r = 0;
                    finish_cmd();
                end
            end
            owbm_pkg::PH_RST_HOLD: begin
                if (b) begin
                    pres_r = 1;
                    finish_cmd();
                end
            end
            owbm_pkg::PH_WR: begin
                low = min1(shreg[0] ? t_one_low : t_zero_low);
                total = (t_slot > low) ? t_slot : low + 1;
                drv = tcnt < low;
                if (++tcnt >= total) slot_end(1'b0);
            end
            owbm_pkg::PH_RD: begin
                low = min1(t_rd_low);
                samp = low + min1(t_rd_samp);
                total = samp + min1(t_rd_tail);
                drv = tcnt < low;
                if (tcnt + 1 == samp) begin
                    pairs = {b, pairs[0]};
                    shreg[0] = 1'b0;
                end
                if (++tcnt >= total) slot_end(pairs[1]);
            end
            default: ;
        endcase
        r = '{drive: drv, busy: ph != owbm_pkg::PH_IDLE, done: done_f, pres: pres_r,
              rdata: rdata_r, dir: dir_r, err: err_r, pass: pass_r, exh: last_fk == 0,
              rom: rom_r};
    endtask

    task automatic cmp_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            mismatches++;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        logic            v;
        owbm_pkg::item_t it;
        if (aresetn) begin
            v = s_valid;
            if (v && s_took) v = 1'b0;
            if (!v && pend_q.size() > 0) begin
                if (s_gap > 0) s_gap--;
                else begin
                    it = pend_q.pop_front();
                    s_func <= it.cmd;
                    s_data_byte <= it.data;
                    s_bus_level <= it.bus;
                    v = 1'b1;
                    s_gap = idle_on ? $urandom_range(0, 7) : 0;
                end
            end
            s_valid <= v;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req) begin
                m_wait = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (m_wait > 0) begin
                m_ready <= 1'b0;
                m_wait--;
            end else m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        tick_result_t e, r;
        logic m_took;
        if (aresetn) begin
            s_took = s_valid && s_ready;
            m_took = m_valid && m_ready;
            if (m_took) begin
                n_results++;
                if (tick_q.size() == 0) begin
                    $error("result transfer with no tick pending");
                    mismatches++;
                end else begin
                    e = tick_q.pop_front();
                    cmp_field("drive_low", e.drive, m_drive_low);
                    cmp_field("busy_res", e.busy, m_busy_res);
                    cmp_field("done_res", e.done, m_done_res);
                    cmp_field("presence", e.pres, m_presence);
                    cmp_field("read_data", e.rdata, m_read_data);
                    cmp_field("search_direction", e.dir, m_search_direction);
                    cmp_field("search_error", e.err, m_search_error);
                    cmp_field("search_pass_done", e.pass, m_search_pass_done);
                    cmp_field("search_exhausted", e.exh, m_search_exhausted);
                    cmp_field("rom_code", e.rom, m_rom_code);
                end
                m_wait = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (s_took) begin
                engine_tick(owbm_pkg::cmd_t'(s_func), s_data_byte, s_bus_level, r);
                tick_q.push_back(r);
                n_ticks++;
                n_done += r.done;
                if (r.done && run_cmd == owbm_pkg::CMD_RESET) n_pres += r.pres;
                if (r.done && run_cmd == owbm_pkg::CMD_SEARCH) begin
                    n_pass += r.pass;
                    n_err += r.err;
                    n_exh += r.exh;
                end
            end
            if (s_took || m_took) stall_cnt = 0;
            else if (++stall_cnt >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push_tick(owbm_pkg::cmd_t f, logic [7:0] d, logic b);
        owbm_pkg::item_t it;
        it.cmd = f; it.data = d; it.bus = b;
        pend_q.push_back(it);
    endtask

    function automatic int unsigned cmd_ticks(owbm_pkg::cmd_t f);
        int unsigned wr, rd;
        wr = min1((t_one_low > t_zero_low) ? t_one_low : t_zero_low) + 1;
        if (t_slot > wr) wr = t_slot;
        rd = min1(t_rd_low) + min1(t_rd_samp) + min1(t_rd_tail);
        case (f)
            owbm_pkg::CMD_RESET:   return min1(t_rst_low) + 2 + min1(t_pres_win) + 6;
            owbm_pkg::CMD_WR_BYTE: return 8 * wr;
            owbm_pkg::CMD_RD_BYTE: return 8 * rd;
            owbm_pkg::CMD_WR_BIT:  return wr;
            owbm_pkg::CMD_RD_BIT:  return rd;
            owbm_pkg::CMD_SEARCH:  return 2 * rd + wr;
            default:               return 1;
        endcase
    endfunction

    // command tick followed by line ticks; when noisy, some carry random commands
    task automatic push_cmd(owbm_pkg::cmd_t f, logic [7:0] d, logic noisy);
        int unsigned n;
        n = cmd_ticks(f) + $urandom_range(0, 3);
        push_tick(f, d, $urandom_range(0, 1));
        repeat (n) begin
            if (noisy && $urandom_range(0, 7) == 0)
                push_tick(owbm_pkg::cmd_t'($urandom_range(1, 7)), $urandom_range(0, 255),
                          $urandom_range(0, 1));
            else push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 1));
        end
    endtask

    task automatic drain();
        forever begin
            while (pend_q.size() > 0 || tick_q.size() > 0 || s_valid) @(negedge aclk);
            if (ph == owbm_pkg::PH_IDLE) break;
            push_tick(owbm_pkg::CMD_NONE, 8'd0, 1'b1);
        end
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(owbm_pkg::cfg_index_t idx, logic [10:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        engine_cfg(idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [10:0] rl, logic [7:0] pw, logic [7:0] one,
                             logic [7:0] zero, logic [7:0] slot, logic [7:0] rdl,
                             logic [7:0] rds, logic [7:0] rdt);
        write_reg(owbm_pkg::CFG_RESET_LOW, rl);
        write_reg(owbm_pkg::CFG_PRES_WIN, {3'd0, pw});
        write_reg(owbm_pkg::CFG_WR_ONE_LOW, {3'd0, one});
        write_reg(owbm_pkg::CFG_WR_ZERO_LOW, {3'd0, zero});
        write_reg(owbm_pkg::CFG_WR_SLOT, {3'd0, slot});
        write_reg(owbm_pkg::CFG_RD_LOW, {3'd0, rdl});
        write_reg(owbm_pkg::CFG_RD_SAMPLE, {3'd0, rds});
        write_reg(owbm_pkg::CFG_RD_TAIL, {3'd0, rdt});
    endtask

    // one search step at minimal timing: samples fall on the 2nd and 5th tick
    task automatic push_search_step(logic a, logic b);
        push_tick(owbm_pkg::CMD_SEARCH, $urandom_range(0, 255), $urandom_range(0, 1));
        push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), a);
        push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 1));
        push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 1));
        push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), b);
        repeat (3) push_tick(owbm_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    task automatic search_pass(logic forks, int steps);
        int   k;
        logic bt;
        for (int i = 0; i < steps; i++) begin
            bt = $urandom_range(0, 1);
            k = $urandom_range(0, 39);
            if (forks && k == 0) push_search_step(1'b1, 1'b1);
            else if (forks && k < 8) push_search_step(1'b0, 1'b0);
            else push_search_step(bt, ~bt);
        end
    endtask

    initial begin
        owbm_pkg::cmd_t f;
        engine_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: zero write slot with busy ignore, search init
        push_cmd(owbm_pkg::CMD_WR_BIT, 8'h00, 1'b1);
        push_cmd(owbm_pkg::CMD_INIT, 8'h00, 1'b0);
        drain();

        // zero timing acts as one
        write_all(11'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 4; i++) push_cmd(owbm_pkg::cmd_t'($urandom_range(1, 7)),
                                             $urandom_range(0, 255), 1'b1);
        drain();

        // random small timings, random commands
        for (int p = 0; p < 2; p++) begin
            write_all($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 4),
                      $urandom_range(1, 6), $urandom_range(2, 8), $urandom_range(1, 3),
                      $urandom_range(1, 3), $urandom_range(1, 3));
            idle_on = (p != 1);
            for (int i = 0; i < 2; i++) begin
                f = owbm_pkg::cmd_t'($urandom_range(1, 7));
                push_cmd(f, $urandom_range(0, 255), 1'b1);
                if (p == 0 && i == 1) hold_req = 1'b1;
            end
            drain();
        end
        idle_on = 1'b1;

        // search: one device to exhaustion, then forked steps and an abort
        write_all(11'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1);
        push_cmd(owbm_pkg::CMD_INIT, 8'h00, 1'b0);
        search_pass(1'b0, 64);
        for (int i = 0; i < 2; i++) push_search_step(1'b0, 1'b1);
        push_cmd(owbm_pkg::CMD_INIT, 8'h00, 1'b0);
        hold_req = 1'b1;
        search_pass(1'b1, 8);
        push_search_step(1'b1, 1'b1);
        drain();

        $display("ticks %0d, results %0d, commands done %0d, presence %0d",
                 n_ticks, n_results, n_done, n_pres);
        $display("search: full passes %0d, aborted %0d, exhausted %0d",
                 n_pass, n_err, n_exh);
        if (mismatches == 0 && tick_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
